// ----- hdl/bit_insertion_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// Bit insertion encoder assertion macros
// Clocked property wrappers used by the assertion checker.
// ----------------------------------------------------------------------------
`ifndef BIT_INSERTION_ENCODER_ASSERT_SVH
`define BIT_INSERTION_ENCODER_ASSERT_SVH

// Property checked only outside reset.
`define BIE_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bie_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder package
// Queue sizing and the records passed between front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bie_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Output bytes of one item: lo_byte alone, or hi_byte then lo_byte
   typedef struct packed {
      logic       two_bytes;
      logic [7:0] hi_byte;
      logic [7:0] lo_byte;
   } bie_entry_type;

   typedef struct packed {
      logic          push;
      bie_entry_type entry;
   } bie_push_type;

   typedef struct packed {
      logic          not_empty;
      bie_entry_type entry;
   } bie_head_type;

endpackage

`default_nettype wire

// ----- hdl/bie_if.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder channels
// Valid/ready channels for input bytes and expanded output bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       insert_here;
   logic [3:0] insert_pos;

   modport source (output valid, output data_byte, output insert_here, output insert_pos,
                   input ready);
   modport sink (input valid, input data_byte, input insert_here, input insert_pos,
                 output ready);
endinterface

interface bie_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/bie_front.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder front
// Accepts bytes, splices in the marker bit, merges pending bits and queues
// the resulting output bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bie_front (
   input  logic                 clock,
   input  logic                 reset,
   bie_req_if.sink              req_ch,
   input  logic                 q_full,
   output bie_pkg::bie_push_type push_out
);
   import bie_pkg::*;

   logic [6:0]  pending_bits_ff;
   logic [6:0]  pending_bits_in;
   logic [2:0]  pending_count_ff;
   logic [2:0]  pending_count_in;
   logic        take;
   logic        mark_ok;
   logic [3:0]  low_n;
   logic [15:0] word;
   logic [15:0] low_mask;
   logic [15:0] spliced;
   logic [15:0] sel_word;
   logic [15:0] shifted;
   logic [2:0]  sel_cnt;
   logic [7:0]  keep_mask;

   assign req_ch.ready = !q_full;
   assign take         = req_ch.valid && !q_full;

   always_comb begin
      mark_ok = req_ch.insert_here && (req_ch.insert_pos >= 4'd1) &&
                (req_ch.insert_pos <= 4'd8);
      low_n    = 4'd9 - req_ch.insert_pos;
      // pending bits sit above the new byte, oldest highest
      word     = {1'b0, pending_bits_ff, req_ch.data_byte};
      low_mask = (16'h0001 << low_n) - 16'h0001;
      spliced  = ((word & ~low_mask) << 1) | (16'h0001 << low_n) | (word & low_mask);

      sel_word  = mark_ok ? spliced : word;
      sel_cnt   = mark_ok ? (pending_count_ff + 3'd1) : pending_count_ff;
      shifted   = sel_word >> sel_cnt;
      keep_mask = (8'h01 << sel_cnt) - 8'h01;

      push_out.push            = take;
      push_out.entry.two_bytes = mark_ok && (pending_count_ff == 3'd7);
      push_out.entry.hi_byte   = spliced[15:8];

      if (push_out.entry.two_bytes) begin
         // sixteen bits ready: emit both bytes, nothing stays pending
         push_out.entry.lo_byte = spliced[7:0];
         pending_bits_in        = 7'd0;
         pending_count_in       = 3'd0;
      end else begin
         push_out.entry.lo_byte = shifted[7:0];
         pending_bits_in        = sel_word[6:0] & keep_mask[6:0];
         pending_count_in       = sel_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= 7'd0;
         pending_count_ff <= 3'd0;
      end else if (take) begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bie_queue.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder queue
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bie_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  bie_pkg::bie_push_type push_in,
   input  logic                  pop,
   output bie_pkg::bie_head_type head_out,
   output logic                  full
);
   import bie_pkg::*;

   bie_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full               = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_out.not_empty = (count_ff != '0);
   assign head_out.entry     = entries_ff[rd_ptr_ff];

   always_comb begin
      do_push = push_in.push && !full;
      do_pop  = pop && head_out.not_empty;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end

      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bie_back.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder back
// Drains queued entries into the output register, one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bie_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bie_pkg::bie_head_type head_in,
   output logic                  pop,
   bie_rsp_if.source             rsp_ch
);
   import bie_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic       second_ff;
   logic       second_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       last_ff;
   logic       last_in;
   logic [7:0] lo_ff;
   logic [7:0] lo_in;
   logic       load;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.last_of_run = last_ff;

   always_comb begin
      load      = !valid_ff || rsp_ch.ready;
      pop       = 1'b0;
      valid_in  = valid_ff;
      second_in = second_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      lo_in     = lo_ff;
      if (load) begin
         if (second_ff) begin
            // finish a two-byte item before taking the next entry
            valid_in  = 1'b1;
            byte_in   = lo_ff;
            last_in   = 1'b1;
            second_in = 1'b0;
         end else if (head_in.not_empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head_in.entry.two_bytes) begin
               byte_in   = head_in.entry.hi_byte;
               last_in   = 1'b0;
               second_in = 1'b1;
               lo_in     = head_in.entry.lo_byte;
            end else begin
               byte_in = head_in.entry.lo_byte;
               last_in = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      lo_ff   <= lo_in;
   end

endmodule

`default_nettype wire

// ----- hdl/bit_insertion_encoder.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder
// Splices optional marker bits into a byte stream and re-packs it into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one input byte per item, with insert_here and insert_pos
//   (1..8; the marker goes above the byte's low 9-pos bits). Out-of-range
//   positions are treated as unmarked bytes.
//   rsp_ch carries the expanded stream, one byte per item. Each input gives
//   one output byte, or two when its marker completes a sixteen-bit word;
//   last_of_run marks the final byte of each input.
//   An accepted input is written to the queue, and the back then loads it
//   into the output register, from which the receiver takes the first output
//   byte. Throughput: one input per cycle while the queue is not full; the
//   output register sends one byte per cycle while the receiver is ready, so
//   a two-byte input holds the output for both bytes and a four-entry queue
//   absorbs the extra byte.
//   Reset clears the pending bits, the queue and the output valid. Pending
//   bits left at the end of a stream are never sent.
//   When the receiver stalls, the output byte holds; the queue keeps taking
//   input until it is full, then req_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bit_insertion_encoder (
   input  logic      clock,
   input  logic      reset,
   bie_req_if.sink   req_ch,
   bie_rsp_if.source rsp_ch
);
   import bie_pkg::*;

   bie_push_type push;
   bie_head_type head;
   logic         q_full;
   logic         pop;

   bie_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push_out (push)
   );

   bie_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (pop),
      .head_out (head),
      .full     (q_full)
   );

   bie_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_in (head),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- hdl/bie_checker.sv -----
// ----------------------------------------------------------------------------
// Bit insertion encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bit_insertion_encoder_assert.svh"

module bie_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // no output right after reset
   `BIE_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "output valid after reset")

   // a stalled output byte holds
   `BIE_ASSERT_RUN(a_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run), "stalled output changed")

   // the second byte of a pair follows at once
   `BIE_ASSERT_RUN(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run, "second byte of pair missing")

endmodule

bind bit_insertion_encoder bie_checker u_bie_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_last_of_run (rsp_ch.last_of_run)
);

`default_nettype wire
